[rtl/local_hexatic_order_defines.svh]
// Assertion macros for the local hexatic order block
`ifndef LOCAL_HEXATIC_ORDER_DEFINES_SVH
`define LOCAL_HEXATIC_ORDER_DEFINES_SVH
`ifndef SYNTHESIS
`define LHO_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define LHO_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define LHO_ASSERT_IMPL(label, clk, rst, a, c)
`define LHO_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[rtl/lho_pkg.sv]
// Package: types, constants and tables for the local hexatic order block
package lho_pkg;
  localparam int MAX_NEIGHBOURS = 32;
  localparam int COORD_WIDTH = 24;
  localparam int ORDER_FRAC_BITS = 16;
  localparam int CORDIC_ITERS = 24;
  localparam int CNT_W = 6;
  localparam int ITER_W = 5;
  localparam int SUM_W = 23;
  localparam logic signed [34:0] CORDIC_K = 35'sd652032874;
  localparam logic signed [34:0] QUARTER = 35'sd1073741824;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_VEC, S_MUL, S_ROT, S_ACC, S_DIV, S_SQ, S_SQRT
  } state_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic vec;
    logic mul;
    logic rot;
    logic acc;
    logic div_start;
    logic div_step;
    logic sq;
    logic sqrt_step;
    logic fin;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic zero_vec;
    logic norm_done;
    logic iter_done;
    logic div_done;
    logic sqrt_done;
    logic full;
  } sts_t;

  function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] i);
    case (i)
      5'd0: atan_lut = 32'd536870912;
      5'd1: atan_lut = 32'd316933406;
      5'd2: atan_lut = 32'd167458907;
      5'd3: atan_lut = 32'd85004756;
      5'd4: atan_lut = 32'd42667331;
      5'd5: atan_lut = 32'd21354465;
      5'd6: atan_lut = 32'd10679838;
      5'd7: atan_lut = 32'd5340245;
      5'd8: atan_lut = 32'd2670163;
      5'd9: atan_lut = 32'd1335087;
      5'd10: atan_lut = 32'd667544;
      5'd11: atan_lut = 32'd333772;
      5'd12: atan_lut = 32'd166886;
      5'd13: atan_lut = 32'd83443;
      5'd14: atan_lut = 32'd41722;
      5'd15: atan_lut = 32'd20861;
      5'd16: atan_lut = 32'd10430;
      5'd17: atan_lut = 32'd5215;
      5'd18: atan_lut = 32'd2608;
      5'd19: atan_lut = 32'd1304;
      5'd20: atan_lut = 32'd652;
      5'd21: atan_lut = 32'd326;
      5'd22: atan_lut = 32'd163;
      5'd23: atan_lut = 32'd81;
      default: atan_lut = 32'd0;
    endcase
  endfunction
endpackage

[rtl/lho_ctrl.sv]
// Controller: sequences one beat through angle, accumulate and result steps
module lho_ctrl import lho_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic has_neighbour,
  input  logic last_neighbour,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  `include "local_hexatic_order_defines.svh"
  state_t state, state_next;
  logic last, last_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      last <= last_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    last_next = last;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          last_next = !has_neighbour || last_neighbour;
          if (has_neighbour && !sts.full) state_next = S_NORM;
          else if (!has_neighbour || last_neighbour) state_next = S_DIV;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (sts.zero_vec) state_next = S_MUL;
        else if (sts.norm_done) state_next = S_VEC;
      end
      S_VEC: begin
        cmd.vec = 1'b1;
        if (sts.iter_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.rot = 1'b1;
        if (sts.iter_done) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_next = last ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        // hold until the output register is free
        if (sts.sqrt_done && (!out_valid || out_ready)) begin
          cmd.fin = 1'b1;
          cmd.clear = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.sq = (state == S_SQ) && sts.div_done;
  end

  `LHO_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `LHO_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `LHO_ASSERT_IMPL(a_fin_free, clk, rst, cmd.fin, !out_valid || out_ready)
  `LHO_ASSERT_NEXT(a_acc_last, clk, rst, cmd.acc && last, state == S_DIV)
endmodule

[rtl/lho_dp.sv]
// Datapath: wrap, CORDIC angle and rotation, sums, mean divide and root
module lho_dp import lho_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic [23:0] box_length,
  input  logic [COORD_WIDTH-1:0] centre_x,
  input  logic [COORD_WIDTH-1:0] centre_y,
  input  logic [COORD_WIDTH-1:0] neighbour_x,
  input  logic [COORD_WIDTH-1:0] neighbour_y,
  output logic signed [17:0] order_real,
  output logic signed [17:0] order_imag,
  output logic [16:0] order_magnitude,
  output logic [CNT_W-1:0] neighbour_count,
  output logic no_neighbours
);
  `include "local_hexatic_order_defines.svh"
  logic signed [34:0] x, y, a;
  logic [31:0] z;
  logic [ITER_W-1:0] it;
  logic neg;
  logic signed [SUM_W-1:0] real_sum, imag_sum;
  logic [CNT_W-1:0] cnt;
  logic signed [26:0] dxr, dyr, dxw, dyw, len;

  assign len = 27'(box_length);
  assign dxr = 27'(neighbour_x) - 27'(centre_x);
  assign dyr = 27'(neighbour_y) - 27'(centre_y);

  function automatic logic signed [26:0] wrap(input logic signed [26:0] d,
                                              input logic signed [26:0] l);
    logic signed [27:0] t;
    t = 28'(d);
    if ((t <<< 1) > 28'(l)) t = t - 28'(l);
    if ((t <<< 1) <= -28'(l)) t = t + 28'(l);
    wrap = t[26:0];
  endfunction

  assign dxw = wrap(dxr, len);
  assign dyw = wrap(dyr, len);

  logic signed [34:0] ax, ay, xs, ys, nx, ny;
  logic signed [34:0] phi_s, a_init;
  logic [31:0] phi, at;
  assign at = atan_lut(it);
  assign ax = x[34] ? -x : x;
  assign ay = y[34] ? -y : y;
  assign xs = x >>> it;
  assign ys = y >>> it;
  assign phi = 32'(z * 32'd6);
  assign phi_s = 35'($signed(phi));

  always_comb begin
    a_init = phi_s;
    if (phi_s > QUARTER) a_init = phi_s - 35'sd2147483648;
    else if (phi_s < -QUARTER) a_init = phi_s + 35'sd2147483648;
  end

  always_comb begin
    if (cmd.vec ? y[34] : !a[34]) begin
      nx = cmd.vec ? x - ys : x - ys;
      ny = cmd.vec ? y + xs : y + xs;
    end else begin
      nx = x + ys;
      ny = y - xs;
    end
  end

  function automatic logic signed [17:0] term(input logic signed [34:0] v, input logic n);
    logic signed [34:0] r;
    r = (v + 35'sd8192) >>> 14;
    if (r > 35'sd65536) r = 35'sd65536;
    if (r < -35'sd65536) r = -35'sd65536;
    term = n ? -r[17:0] : r[17:0];
  endfunction

  // divider and root
  logic [SUM_W-1:0] dnum, dq;
  logic [CNT_W+SUM_W:0] drem;
  logic [ITER_W-1:0] dit;
  logic dsr, dphase;
  logic signed [17:0] re, im;
  logic [35:0] srem, sr, sbit;
  logic sbusy;
  logic [CNT_W+SUM_W:0] dtry;
  assign dtry = {drem[CNT_W+SUM_W-1:0], dnum[SUM_W-1]};

  assign sts.zero_vec = (x == 0) && (y == 0);
  assign sts.norm_done = (ax >= QUARTER) || (ay >= QUARTER);
  assign sts.iter_done = it == ITER_W'(CORDIC_ITERS - 1);
  assign sts.div_done = !dphase;
  assign sts.sqrt_done = sbusy && (sbit == 0);
  assign sts.full = cnt >= CNT_W'(MAX_NEIGHBOURS);

  always_ff @(posedge clk) begin
    if (rst) begin
      real_sum <= '0;
      imag_sum <= '0;
      cnt <= '0;
      dphase <= 1'b0;
      sbusy <= 1'b0;
    end else begin
      if (cmd.load) begin
        x <= 35'(dxw);
        y <= 35'(dyw);
        z <= '0;
        it <= '0;
      end
      if (cmd.norm && !sts.zero_vec) begin
        if (!sts.norm_done) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end else if (x[34]) begin
          x <= -x;
          y <= -y;
          z <= 32'h8000_0000;
        end
      end
      if (cmd.vec) begin
        x <= nx;
        y <= ny;
        z <= y[34] ? z - at : z + at;
        it <= it + 1'b1;
      end
      if (cmd.mul) begin
        a <= a_init;
        neg <= a_init != phi_s;
        x <= CORDIC_K;
        y <= '0;
        it <= '0;
      end
      if (cmd.rot) begin
        x <= nx;
        y <= ny;
        a <= !a[34] ? a - 35'(at) : a + 35'(at);
        it <= it + 1'b1;
      end
      if (cmd.acc) begin
        real_sum <= real_sum + SUM_W'(term(x, neg));
        imag_sum <= imag_sum + SUM_W'(term(y, neg));
        cnt <= cnt + 1'b1;
      end
      if (cmd.div_start) begin
        dsr <= 1'b0;
        dphase <= 1'b1;
        dit <= '0;
        drem <= '0;
        dnum <= (real_sum[SUM_W-1] ? -real_sum : real_sum) + SUM_W'(cnt >> 1);
        dq <= '0;
      end
      if (cmd.div_step && dphase) begin
        if (dit == ITER_W'(SUM_W)) begin
          if (!dsr) begin
            re <= (cnt == 0) ? '0 : (real_sum[SUM_W-1] ? -18'(dq) : 18'(dq));
            dsr <= 1'b1;
            dit <= '0;
            drem <= '0;
            dnum <= (imag_sum[SUM_W-1] ? -imag_sum : imag_sum) + SUM_W'(cnt >> 1);
            dq <= '0;
          end else begin
            im <= (cnt == 0) ? '0 : (imag_sum[SUM_W-1] ? -18'(dq) : 18'(dq));
            dphase <= 1'b0;
          end
        end else begin
          dit <= dit + 1'b1;
          dnum <= dnum << 1;
          if (cnt != 0 && dtry >= (CNT_W+SUM_W+1)'(cnt)) begin
            drem <= dtry - (CNT_W+SUM_W+1)'(cnt);
            dq <= {dq[SUM_W-2:0], 1'b1};
          end else begin
            drem <= dtry;
            dq <= {dq[SUM_W-2:0], 1'b0};
          end
        end
      end
      if (cmd.sq) begin
        srem <= 36'($unsigned(36'(re) * 36'(re))) + 36'($unsigned(36'(im) * 36'(im)));
        sr <= '0;
        sbit <= 36'h4_0000_0000;
        sbusy <= 1'b1;
      end
      if (cmd.sqrt_step && sbusy && sbit != 0) begin
        if (srem >= sr + sbit) begin
          srem <= srem - (sr + sbit);
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
      end
      if (cmd.fin) begin
        sbusy <= 1'b0;
        order_real <= re;
        order_imag <= im;
        order_magnitude <= (srem > sr) ?
          ((sr + 36'd1 > 36'd65536) ? 17'd65536 : 17'(sr + 36'd1)) :
          ((sr > 36'd65536) ? 17'd65536 : 17'(sr));
        neighbour_count <= cnt;
        no_neighbours <= cnt == 0;
      end
      if (cmd.clear) begin
        real_sum <= '0;
        imag_sum <= '0;
        cnt <= '0;
      end
    end
  end

  `LHO_ASSERT_IMPL(a_cnt_max, clk, rst, 1'b1, cnt <= CNT_W'(MAX_NEIGHBOURS))
  `LHO_ASSERT_NEXT(a_acc_cnt, clk, rst, cmd.acc, cnt == $past(cnt) + 1'b1)
  `LHO_ASSERT_NEXT(a_clear, clk, rst, cmd.clear, cnt == 0)
endmodule

[rtl/local_hexatic_order.sv]
// Top level: local sixfold bond-orientational order of one particle
// channel   signals                               direction
// cfg       cfg_valid cfg_ready cfg_data          in
// in        in_valid in_ready centre/neighbour    in
// out       out_valid out_ready order fields      out
// A neighbour beat runs up to 30 normalizing shifts, then 24 vectoring and
// 24 rotation CORDIC steps on one unit; a coincident pair skips the shifts and
// vectoring, a beat past the cap is dropped. End of particle: setup, divider
// (two means), root. The result then sits in the output register; a result
// still held there stalls the next particle at its root step. Reset clears
// sums and count and sets box length to 9183232.
module local_hexatic_order import lho_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [23:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [COORD_WIDTH-1:0] centre_x,
  input  logic [COORD_WIDTH-1:0] centre_y,
  input  logic [COORD_WIDTH-1:0] neighbour_x,
  input  logic [COORD_WIDTH-1:0] neighbour_y,
  input  logic has_neighbour,
  input  logic last_neighbour,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [17:0] order_real,
  output logic signed [17:0] order_imag,
  output logic [16:0] order_magnitude,
  output logic [CNT_W-1:0] neighbour_count,
  output logic no_neighbours
);
  logic [23:0] box_length;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) box_length <= 24'd9183232;
    else if (cfg_valid) box_length <= cfg_data;
  end

  lho_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .has_neighbour(has_neighbour), .last_neighbour(last_neighbour),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  lho_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .box_length(box_length),
    .centre_x(centre_x), .centre_y(centre_y),
    .neighbour_x(neighbour_x), .neighbour_y(neighbour_y),
    .order_real(order_real), .order_imag(order_imag),
    .order_magnitude(order_magnitude), .neighbour_count(neighbour_count),
    .no_neighbours(no_neighbours)
  );
endmodule

[tb/sv/local_hexatic_order_test.sv]
// Testbench for local_hexatic_order: directed and random particles against a psi6 predictor
module local_hexatic_order_test;
  import lho_pkg::*;

  typedef struct {
    logic [23:0] cx, cy, nx, ny;
    logic        has, last;
    logic        chk;
    int          re, im, mag, cnt;
    logic        none;
  } beat_t;

  typedef struct {
    logic signed [17:0] re;
    logic signed [17:0] im;
    logic [16:0]        mag;
    logic [5:0]         cnt;
    logic               none;
  } order_t;

  localparam longint ATAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };
  localparam longint QTURN = 64'sd1073741824;
  localparam longint HTURN = 64'sd2147483648;
  localparam longint UNIT  = 64'sd65536;
  localparam int     PHASE_BEATS = 350;
  localparam int     SETTLE = 150;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [COORD_WIDTH-1:0] centre_x = '0, centre_y = '0, neighbour_x = '0, neighbour_y = '0;
  logic has_neighbour = 0, last_neighbour = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [17:0] order_real, order_imag;
  logic [16:0] order_magnitude;
  logic [CNT_W-1:0] neighbour_count;
  logic no_neighbours;

  local_hexatic_order dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .centre_x(centre_x), .centre_y(centre_y),
    .neighbour_x(neighbour_x), .neighbour_y(neighbour_y),
    .has_neighbour(has_neighbour), .last_neighbour(last_neighbour),
    .out_valid(out_valid), .out_ready(out_ready),
    .order_real(order_real), .order_imag(order_imag),
    .order_magnitude(order_magnitude), .neighbour_count(neighbour_count),
    .no_neighbours(no_neighbours)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor state
  longint box_len = 9183232;
  longint re_acc = 0, im_acc = 0;
  int     bond_cnt = 0;
  order_t pending_orders[$];
  beat_t  pending_beats[$];
  int     mismatches = 0;
  int     beats_sent = 0, orders_seen = 0, empty_seen = 0, full_seen = 0;

  function automatic longint min_image(longint d, longint len);
    if (2 * d > len) d -= len;
    if (2 * d <= -len) d += len;
    return d;
  endfunction

  function automatic logic [31:0] bond_angle(longint x, longint y);
    logic [31:0] z;
    longint nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (((x < 0 ? -x : x) < QTURN) && ((y < 0 ? -y : y) < QTURN)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 24; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - ATAN[i][31:0];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + ATAN[i][31:0];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint q16_term(longint v);
    longint r;
    r = (v + (64'sd1 <<< 13)) >>> 14;
    if (r > UNIT) r = UNIT;
    if (r < -UNIT) r = -UNIT;
    return r;
  endfunction

  function automatic void harmonic(logic [31:0] phi, output longint c, output longint s);
    longint a, x, y, nx, ny;
    logic flip;
    a = phi[31] ? longint'(phi) - 2 * HTURN : longint'(phi);
    flip = 0;
    x = 652032874;
    y = 0;
    if (a > QTURN) begin
      a -= HTURN;
      flip = 1;
    end else if (a < -QTURN) begin
      a += HTURN;
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        a -= ATAN[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        a += ATAN[i];
      end
      x = nx;
      y = ny;
    end
    c = q16_term(x);
    s = q16_term(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic longint rounded_mean(longint s, longint n);
    longint m, q;
    m = s < 0 ? -s : s;
    q = (m + n / 2) / n;
    return s < 0 ? -q : q;
  endfunction

  function automatic longint root_nearest(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    if (v > lo * lo + lo) lo++;
    return lo;
  endfunction

  function automatic void predict_order(beat_t b);
    longint dx, dy, c, s, re, im, mag;
    logic [31:0] phi;
    order_t o;
    if (b.has && bond_cnt < MAX_NEIGHBOURS) begin
      dx = min_image(longint'(b.nx) - longint'(b.cx), box_len);
      dy = min_image(longint'(b.ny) - longint'(b.cy), box_len);
      phi = bond_angle(dx, dy) * 32'd6;
      harmonic(phi, c, s);
      re_acc += c;
      im_acc += s;
      bond_cnt++;
    end
    if (b.has && !b.last) return;
    re = 0; im = 0; mag = 0;
    if (bond_cnt != 0) begin
      re = rounded_mean(re_acc, bond_cnt);
      im = rounded_mean(im_acc, bond_cnt);
      mag = root_nearest(re * re + im * im);
      if (mag > UNIT) mag = UNIT;
    end
    o.re = re[17:0];
    o.im = im[17:0];
    o.mag = mag[16:0];
    o.cnt = bond_cnt[5:0];
    o.none = bond_cnt == 0;
    if (b.chk && (o.re != b.re[17:0] || o.im != b.im[17:0] || o.mag != b.mag[16:0] ||
                  o.cnt != b.cnt[5:0] || o.none != b.none)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row exp %0d %0d %0d %0d %0d, predicted %0d %0d %0d %0d %0d",
                 b.re, b.im, b.mag, b.cnt, b.none, o.re, o.im, o.mag, o.cnt, o.none);
    end
    if (bond_cnt == 0) empty_seen++;
    if (bond_cnt == MAX_NEIGHBOURS) full_seen++;
    pending_orders.push_back(o);
    re_acc = 0;
    im_acc = 0;
    bond_cnt = 0;
  endfunction

  always @(posedge clk) begin
    order_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        orders_seen++;
        if (pending_orders.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result re %0d im %0d", order_real, order_imag);
        end else begin
          e = pending_orders.pop_front();
          if (order_real !== e.re || order_imag !== e.im || order_magnitude !== e.mag ||
              neighbour_count !== e.cnt || no_neighbours !== e.none) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                       e.re, e.im, e.mag, e.cnt, e.none, order_real, order_imag,
                       order_magnitude, neighbour_count, no_neighbours);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_order(pending_beats.pop_front());
        beats_sent++;
      end
      if (cfg_valid && cfg_ready) box_len = longint'(cfg_data);
    end
  end

  function automatic int draw_wait(inout logic burst);
    if ($urandom_range(0, 99) < 3) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  logic tx_burst = 0, rx_burst = 0;

  task automatic send_beat(beat_t b);
    int w;
    w = draw_wait(tx_burst);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    pending_beats.push_back(b);
    centre_x <= b.cx;
    centre_y <= b.cy;
    neighbour_x <= b.nx;
    neighbour_y <= b.ny;
    has_neighbour <= b.has;
    last_neighbour <= b.last;
    in_valid <= 1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain_and_settle();
    in_valid <= 0;
    while (pending_orders.size() != 0 || pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_box(logic [23:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 0;
  endtask

  task automatic send_particle(output int n_beats);
    beat_t b;
    int pick, n, spread;
    pick = $urandom_range(0, 19);
    n = pick == 0 ? 0 : (pick < 17 ? $urandom_range(1, 10) : $urandom_range(30, 40));
    spread = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h03FFFF;
    b.cx = 24'($urandom);
    b.cy = 24'($urandom);
    b.chk = 0;
    if (n == 0) begin
      b.nx = 24'($urandom);
      b.ny = 24'($urandom);
      b.has = 0;
      b.last = 1'($urandom_range(0, 1));
      send_beat(b);
      n_beats = 1;
      return;
    end
    for (int k = 0; k < n; k++) begin
      b.nx = 24'(b.cx + ($urandom & spread) - (spread >> 1));
      b.ny = 24'(b.cy + ($urandom & spread) - (spread >> 1));
      if ($urandom_range(0, 31) == 0) begin
        b.nx = b.cx;
        b.ny = b.cy;
      end
      b.has = 1;
      b.last = k == n - 1;
      send_beat(b);
    end
    n_beats = n;
  endtask

  beat_t dir_tab [14] = '{
    '{24'h0, 24'h0, 24'h0, 24'h0, 0, 0, 1, 0, 0, 0, 0, 1},
    '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1, 1, 0, 0, 0, 0, 1},
    '{24'h186A0, 24'h186A0, 24'h186A0, 24'h186A0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{24'h0, 24'h0, 24'h0, 24'h0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 1, 1, 0, 0, 0, 0, 0, 0},
    '{24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{24'h100000, 24'h100000, 24'h110000, 24'h100000, 1, 0, 0, 0, 0, 0, 0, 0},
    '{24'h100000, 24'h100000, 24'h100000, 24'h110000, 1, 0, 0, 0, 0, 0, 0, 0},
    '{24'h100000, 24'h100000, 24'h0F0000, 24'h100000, 1, 0, 0, 0, 0, 0, 0, 0},
    '{24'h100000, 24'h100000, 24'h100000, 24'h0F0000, 1, 1, 0, 0, 0, 0, 0, 0},
    '{24'h200000, 24'h200000, 24'h210000, 24'h209000, 1, 0, 0, 0, 0, 0, 0, 0},
    '{24'h200000, 24'h200000, 24'h0, 24'h0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{24'h800000, 24'h000000, 24'h000000, 24'hFFFFFF, 1, 1, 0, 0, 0, 0, 0, 0},
    '{24'h000000, 24'h800000, 24'hFFFFFF, 24'h000000, 1, 0, 0, 0, 0, 0, 0, 0}
  };

  initial begin
    int n, phase_beats;
    logic [23:0] boxes [5];
    boxes = '{24'd9183232, 24'd1, 24'hFFFFFF, 24'd0, 24'd9183232};
    boxes[3] = 24'($urandom_range(1, 24'hFFFFFF));
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    for (int p = 0; p < 5; p++) begin
      drain_and_settle();
      if (p > 0) write_box(boxes[p]);
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        send_particle(n);
        phase_beats += n;
      end
    end
    // wait for the last results
    drain_and_settle();
    while (pending_orders.size() != 0) @(posedge clk);
    in_valid <= 0;
    repeat (SETTLE) @(posedge clk);
    $display("%0d beats, %0d results (%0d empty lists, %0d capped at %0d neighbours)",
             beats_sent, orders_seen, empty_seen, full_seen, MAX_NEIGHBOURS);
    $display("box lengths covered: reset value, 1, full scale, one random; mismatches %0d",
             mismatches);
    if (mismatches == 0) begin
      $display("local_hexatic_order_test: clean");
    end else begin
      $display("local_hexatic_order_test: errors");
    end
    $finish;
  end

  initial begin
    int w, taken;
    logic held;
    taken = 0;
    held = 0;
    @(negedge rst);
    forever begin
      w = draw_wait(rx_burst);
      if (!held && taken == 15) begin
        held = 1;
        w = 2000;
      end
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    #(4 * 3000000);
    $display("timeout after %0d beats, %0d results", beats_sent, orders_seen);
    $display("local_hexatic_order_test: errors");
    $finish;
  end
endmodule
